// ----- hdl/md5_pkg.sv -----
// MD5 constants, round tables and helper functions shared by the digest block.
package md5_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned WIDX_W   = $clog2(BLK_WORDS);
  localparam int unsigned RND_W    = 6;
  localparam int unsigned LEN_W    = 64;
  localparam int unsigned BCNT_W   = LEN_W - 3;

  localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [WIDX_W-1:0] LEN_LO_WORD = 4'd14;
  localparam logic [WIDX_W-1:0] LEN_HI_WORD = 4'd15;

  localparam logic [WORD_W-1:0] K_TBL [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TBL [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [WIDX_W-1:0] msg_word_idx(input logic [RND_W-1:0] rnd);
    logic [WIDX_W-1:0] lo;
    lo = rnd[WIDX_W-1:0];
    case (rnd[5:4])
      2'd0:    return lo;
      2'd1:    return WIDX_W'(lo * 4'd5 + 4'd1);
      2'd2:    return WIDX_W'(lo * 4'd3 + 4'd5);
      default: return WIDX_W'(lo * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] rot_amt(input logic [RND_W-1:0] rnd);
    return ROT_TBL[{rnd[5:4], rnd[1:0]}];
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

// ----- hdl/md5_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/md5_message_digest.sv -----
// MD5 digest block: byte gathering, padding sequencer and one-round-per-cycle core.
//
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid_i/in_stall_o | data_byte_i, has_byte_i, last_i
//  out     | source    | out_valid_o/out_stall_i | digest_low_o, digest_high_o
//
// A byte item is taken while idle; every 64th byte then runs the block: 64 rounds from the
// block store RAM, one read per round, then the chaining add.
// A last item takes one pad-word write, up to 17 fill writes and one or two blocks,
// then loads the digest register; a last item with no byte seen loads a zero digest.
// Reset loads the MD5 initial chaining words and clears the count; no clearing pass.
// The input stalls while a block or the padding runs, and while a finished digest
// waits for the full output register to drain.
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o
);

  import md5_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_FILL = 6'b000100,
    ST_RUN  = 6'b001000,
    ST_FOLD = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [WORD_W-1:0]    chain_q [4];
  logic [WORD_W-1:0]    chain_d [4];
  logic [WORD_W-1:0]    a_q, b_q, c_q, d_q;
  logic [WORD_W-1:0]    a_d, b_d, c_d, d_d;
  logic [BCNT_W-1:0]    bytes_q, bytes_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic [RND_W-1:0]     rnd_q, rnd_d;
  logic [WIDX_W-1:0]    widx_q, widx_d;
  logic                 seen_q, seen_d;
  logic                 last_pend_q, last_pend_d;
  logic                 pad_act_q, pad_act_d;
  logic                 fin_blk_q, fin_blk_d;
  logic                 zero_q, zero_d;
  logic                 out_valid_q, out_valid_d;
  logic [63:0]          dlow_q, dlow_d, dhigh_q, dhigh_d;

  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  logic                 in_fire, out_free;
  logic [5:0]           byte_idx;
  logic [WORD_W-1:0]    pad_word, f_val, sum, b_new;
  logic [LEN_W-1:0]     len_bits;
  logic [RND_W-1:0]     rnd_nxt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign byte_idx   = bytes_q[5:0];
  assign len_bits   = {bytes_q, 3'b000};
  assign rnd_nxt    = rnd_q + 6'd1;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (l < int'(byte_idx[1:0])) begin
        pad_word[8*l +: 8] = word_q[8*l +: 8];
      end else if (l == int'(byte_idx[1:0])) begin
        pad_word[8*l +: 8] = PAD_BYTE;
      end else begin
        pad_word[8*l +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    sum   = a_q + f_val + K_TBL[rnd_q] + ram_rdata;
    b_new = b_q + rotl32(sum, rot_amt(rnd_q));
  end

  assign ram_raddr = (state_q == ST_RUN) ? msg_word_idx(rnd_nxt) : '0;

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    a_d         = chain_q[0];
    b_d         = chain_q[1];
    c_d         = chain_q[2];
    d_d         = chain_q[3];
    bytes_d     = bytes_q;
    word_d      = word_q;
    rnd_d       = '0;
    widx_d      = widx_q;
    seen_d      = seen_q;
    last_pend_d = last_pend_q;
    pad_act_d   = pad_act_q;
    fin_blk_d   = fin_blk_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    dlow_d      = dlow_q;
    dhigh_d     = dhigh_q;
    ram_we      = 1'b0;
    ram_waddr   = widx_q;
    ram_wdata   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_byte_i) begin
            word_d[8*byte_idx[1:0] +: 8] = data_byte_i;
            bytes_d = bytes_q + 1'b1;
            seen_d  = 1'b1;
            if (byte_idx[1:0] == 2'd3) begin
              ram_we    = 1'b1;
              ram_waddr = byte_idx[5:2];
              ram_wdata = {data_byte_i, word_q[23:0]};
            end
            if (byte_idx == 6'd63) begin
              state_d     = ST_RUN;
              last_pend_d = last_i;
            end else if (last_i) begin
              state_d   = ST_PAD;
              pad_act_d = 1'b1;
            end
          end else if (last_i) begin
            if (seen_q) begin
              state_d   = ST_PAD;
              pad_act_d = 1'b1;
            end else begin
              state_d = ST_EMIT;
              zero_d  = 1'b1;
            end
          end
        end
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_waddr = byte_idx[5:2];
        ram_wdata = pad_word;
        widx_d    = byte_idx[5:2] + 1'b1;
        fin_blk_d = (byte_idx[5:2] < LEN_LO_WORD);
        state_d   = (byte_idx[5:2] == LEN_HI_WORD) ? ST_RUN : ST_FILL;
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (fin_blk_q && widx_q == LEN_LO_WORD) begin
          ram_wdata = len_bits[31:0];
        end else if (fin_blk_q && widx_q == LEN_HI_WORD) begin
          ram_wdata = len_bits[63:32];
        end
        widx_d = widx_q + 1'b1;
        if (widx_q == LEN_HI_WORD) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        a_d   = d_q;
        b_d   = b_new;
        c_d   = b_q;
        d_d   = c_q;
        rnd_d = rnd_nxt;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        if (pad_act_q) begin
          if (fin_blk_q) begin
            state_d = ST_EMIT;
          end else begin
            fin_blk_d = 1'b1;
            widx_d    = '0;
            state_d   = ST_FILL;
          end
        end else if (last_pend_q) begin
          last_pend_d = 1'b0;
          pad_act_d   = 1'b1;
          state_d     = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          dlow_d      = zero_q ? '0 : {chain_q[1], chain_q[0]};
          dhigh_d     = zero_q ? '0 : {chain_q[3], chain_q[2]};
          chain_d[0]  = IV_A;
          chain_d[1]  = IV_B;
          chain_d[2]  = IV_C;
          chain_d[3]  = IV_D;
          bytes_d     = '0;
          seen_d      = 1'b0;
          last_pend_d = 1'b0;
          pad_act_d   = 1'b0;
          fin_blk_d   = 1'b0;
          zero_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q[0]  <= IV_A;
      chain_q[1]  <= IV_B;
      chain_q[2]  <= IV_C;
      chain_q[3]  <= IV_D;
      bytes_q     <= '0;
      rnd_q       <= '0;
      widx_q      <= '0;
      seen_q      <= 1'b0;
      last_pend_q <= 1'b0;
      pad_act_q   <= 1'b0;
      fin_blk_q   <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      bytes_q     <= bytes_d;
      rnd_q       <= rnd_d;
      widx_q      <= widx_d;
      seen_q      <= seen_d;
      last_pend_q <= last_pend_d;
      pad_act_q   <= pad_act_d;
      fin_blk_q   <= fin_blk_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    d_q     <= d_d;
    word_q  <= word_d;
    dlow_q  <= dlow_d;
    dhigh_q <= dhigh_d;
  end

  md5_ram #(
    .Width (WORD_W),
    .Depth (BLK_WORDS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_low_o  = dlow_q;
  assign digest_high_o = dhigh_q;

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
    else $error("round counter did not end the block in the fold cycle");

  a_no_wr_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_RUN && state_q != ST_FOLD && state_q != ST_EMIT))
    else $error("block store written while rounds read it");

  a_emit_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (pad_act_q || zero_q))
    else $error("digest emitted without a closed message");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the emit step");

endmodule
